@@ design/krme_pkg.sv @@
// ----------------------------------------------------------------------------
// krme_pkg
// Shared types and constants for the keyboard report to MIDI event block.
// ----------------------------------------------------------------------------
package krme_pkg;

    localparam int KeyCount      = 25;
    localparam int DrumKeys      = 12;
    localparam int VelocitySlots = 5;
    localparam int MaxMsgs       = 32;
    localparam int KeyIdxW       = $clog2(KeyCount);
    localparam int MsgCntW       = $clog2(MaxMsgs + 1);

    localparam logic [7:0] StProgram  = 8'hC0;
    localparam logic [7:0] StStart    = 8'hFA;
    localparam logic [7:0] StContinue = 8'hFB;
    localparam logic [7:0] StStop     = 8'hFC;
    localparam logic [7:0] StCtrl     = 8'hB0;
    localparam logic [7:0] StCtrlDrum = 8'hB9;
    localparam logic [7:0] StBend     = 8'hE0;
    localparam logic [7:0] StNoteOn   = 8'h90;
    localparam logic [7:0] StNoteOff  = 8'h80;
    localparam logic [7:0] CcAllOff   = 8'h7B;
    localparam logic [7:0] CcMod      = 8'h01;
    localparam logic [7:0] CcDamper   = 8'h40;
    localparam logic [6:0] VelDefault = 7'h40;
    localparam logic [6:0] BaseReset  = 7'd48;
    localparam logic [6:0] BaseTop    = 7'd84;

    localparam logic [3:0] PadUp     = 4'd0;
    localparam logic [3:0] PadRight  = 4'd2;
    localparam logic [3:0] PadDown   = 4'd4;
    localparam logic [3:0] PadLeft   = 4'd6;
    localparam logic [3:0] PadCenter = 4'd8;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HEAD = 5'b00010,
        S_KEYS = 5'b00100,
        S_OUT  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    // One queued MIDI message.
    typedef struct packed {
        logic [7:0] status;
        logic [7:0] data1;
        logic [7:0] data2;
    } t_msg;

    // Drum map for the lowest keys.
    function automatic logic [6:0] drum_note(input logic [KeyIdxW-1:0] k);
        logic [6:0] n;
        n = 7'd35;
        case (k)
            5'd0:  n = 7'd35;
            5'd1:  n = 7'd36;
            5'd2:  n = 7'd38;
            5'd3:  n = 7'd40;
            5'd4:  n = 7'd41;
            5'd5:  n = 7'd47;
            5'd6:  n = 7'd50;
            5'd7:  n = 7'd42;
            5'd8:  n = 7'd46;
            5'd9:  n = 7'd49;
            5'd10: n = 7'd51;
            5'd11: n = 7'd53;
            default: n = 7'd35;
        endcase
        return n;
    endfunction

endpackage

@@ design/krme_ram.sv @@
// ----------------------------------------------------------------------------
// krme_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module krme_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/keyboard_report_to_midi_events_top.sv @@
// ----------------------------------------------------------------------------
// keyboard_report_to_midi_events_top
// Compares each keyboard report with the previous one and emits MIDI messages.
//
//  channel | direction | handshake        | payload
//  report  | in        | i_valid/o_stall  | buttons, pad, keys, velocities,
//          |           |                  | bend select, pedal, wheel
//  midi    | out       | o_valid/i_stall  | status, data1, data2, last flag
//
// After a report is accepted, the sequencer steps through the header slots,
// then through the keys one at a time, and then starts the queue read.
// A report with no messages frees the input once that read step is done.
// Otherwise each message is read from the queue and presented until taken,
// and the next report is accepted after the last message is taken.
// Reset restores the previous-report state; output stalls hold the walk.
// ----------------------------------------------------------------------------
module keyboard_report_to_midi_events_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_front_buttons,
    input  logic [7:0]  i_transport_buttons,
    input  logic [3:0]  i_pad_direction,
    input  logic [24:0] i_key_bits,
    input  logic [6:0]  i_velocity_0,
    input  logic [6:0]  i_velocity_1,
    input  logic [6:0]  i_velocity_2,
    input  logic [6:0]  i_velocity_3,
    input  logic [6:0]  i_velocity_4,
    input  logic [7:0]  i_bend_select,
    input  logic [7:0]  i_pedal_byte,
    input  logic [7:0]  i_wheel_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_midi_status,
    output logic [7:0]  o_midi_data1,
    output logic [7:0]  o_midi_data2,
    output logic        o_last_message
);
    localparam int KW = krme_pkg::KeyIdxW;
    localparam int CW = krme_pkg::MsgCntW;
    localparam int QW = $clog2(krme_pkg::MaxMsgs);

    krme_pkg::t_state r_state, n_state;

    // Latched report.
    logic [7:0]  r_fb, r_tb, r_bs, r_ped, r_wh;
    logic [3:0]  r_pad;
    logic [24:0] r_keys;
    logic [6:0]  r_vel [krme_pkg::VelocitySlots];

    // Persistent state.
    logic [7:0]  r_pfb, r_ptb, r_pbs, r_pped, r_pwh;
    logic [3:0]  r_ppad;
    logic [24:0] r_pkeys;
    logic [6:0]  r_base, r_prog, r_pctl;
    logic        r_drum;
    logic [4:0]  r_held;
    logic [11:0] r_on_drums;

    // Key walk.
    logic [KW-1:0] r_k;
    logic [4:0]    r_below;

    // Message queue.
    logic [CW-1:0] r_wcnt, r_rptr;
    logic          r_qwe;
    logic [QW-1:0] r_qwaddr;
    krme_pkg::t_msg r_qwdata, w_qrdata;

    // Note store.
    logic          w_nwe;
    logic [6:0]    w_nrdata, w_nwdata;
    logic          r_out_wait;

    krme_ram #(.Width(24), .Depth(krme_pkg::MaxMsgs)) u_queue (
        .i_clk  (i_clk),
        .i_we   (r_qwe),
        .i_waddr(r_qwaddr),
        .i_wdata(r_qwdata),
        .i_raddr(r_rptr[QW-1:0]),
        .o_rdata(w_qrdata)
    );

    // The store is read one key ahead so that its data is ready at each key step.
    logic [KW-1:0] w_nraddr;
    assign w_nraddr = (r_state == krme_pkg::S_KEYS) ? r_k + KW'(1) : '0;

    krme_ram #(.Width(7), .Depth(krme_pkg::KeyCount)) u_notes (
        .i_clk  (i_clk),
        .i_we   (w_nwe),
        .i_waddr(r_k),
        .i_wdata(w_nwdata),
        .i_raddr(w_nraddr),
        .o_rdata(w_nrdata)
    );

    assign o_stall = (r_state != krme_pkg::S_IDLE);
    logic w_acc;
    assign w_acc = i_valid && !o_stall;

    // Key walk combinational step.
    logic          w_cv, w_lv, w_chg, w_drumk;
    logic [4:0]    w_bit;
    logic [6:0]    w_note, w_v;
    logic [3:0]    w_ch;
    always_comb begin
        w_bit   = 5'(krme_pkg::KeyCount - 1) - 5'(r_k);
        w_cv    = r_keys[w_bit];
        w_lv    = r_pkeys[w_bit];
        w_chg   = w_cv != w_lv;
        w_drumk = r_k < KW'(krme_pkg::DrumKeys);
        w_ch    = 4'd0;
        w_note  = r_base + 7'(r_k);
        if (w_drumk && r_drum) begin
            w_ch   = 4'd9;
            w_note = krme_pkg::drum_note(r_k);
        end
        w_v = krme_pkg::VelDefault;
        if (r_held < 5'(krme_pkg::VelocitySlots)
                && r_below < 5'(krme_pkg::VelocitySlots)) begin
            w_v = r_vel[r_below[2:0]];
        end
        w_nwe    = (r_state == krme_pkg::S_KEYS) && w_chg && w_cv;
        w_nwdata = w_note;
    end

    // Header messages: computed from latched report and previous state.
    logic w_pup, w_pdn, w_st, w_co, w_sp, w_all3, w_whl, w_pana, w_pdmp;
    always_comb begin
        w_pup  = r_fb[3] && !r_pfb[3];
        w_pdn  = r_fb[1] && !r_pfb[1];
        w_st   = r_tb[1] && !r_ptb[1];
        w_co   = r_tb[4] && !r_ptb[4];
        w_sp   = r_tb[0] && !r_ptb[0];
        w_all3 = (w_st || w_co || w_sp) && (r_tb & 8'h13) == 8'h13;
        w_whl  = r_wh != r_pwh && r_bs == r_pbs && r_wh != 8'd0;
        w_pana = r_ped[6:0] != r_pped[6:0];
        w_pdmp = r_ped[7] != r_pped[7];
    end

    // Header emission index (at most one message per cycle in S_HEAD).
    logic [3:0]        r_hstep;
    logic              w_hemit, w_hlast;
    krme_pkg::t_msg    w_hmsg;
    logic [6:0]        w_newprog;
    always_comb begin
        w_newprog = r_prog;
        if ((w_pup || w_pdn) && r_fb[3] && r_fb[1]) w_newprog = 7'd0;
        else if (w_pup) w_newprog = r_prog + 7'd1;
        else if (w_pdn) w_newprog = r_prog - 7'd1;
        w_hemit = 1'b0;
        w_hmsg  = '0;
        case (r_hstep)
            4'd0: begin
                w_hemit = w_pup || w_pdn;
                w_hmsg  = '{krme_pkg::StProgram, {1'b0, w_newprog}, 8'd0};
            end
            4'd1: begin
                w_hemit = w_all3 || w_st || w_co || w_sp;
                w_hmsg.status = w_all3 ? krme_pkg::StStop :
                                w_st ? krme_pkg::StStart :
                                w_co ? krme_pkg::StContinue : krme_pkg::StStop;
            end
            4'd2: begin
                w_hemit = w_all3;
                w_hmsg  = '{krme_pkg::StCtrl, krme_pkg::CcAllOff, 8'd0};
            end
            4'd3: begin
                w_hemit = w_all3;
                w_hmsg  = '{krme_pkg::StCtrlDrum, krme_pkg::CcAllOff, 8'd0};
            end
            4'd4: begin
                w_hemit = w_whl;
                if (r_bs[7]) begin
                    w_hmsg = '{krme_pkg::StBend, 8'd0, r_wh - 8'd1};
                end else begin
                    w_hmsg = '{krme_pkg::StCtrl, krme_pkg::CcMod, r_wh - 8'd1};
                end
            end
            4'd5: begin
                w_hemit = w_pana;
                w_hmsg  = '{krme_pkg::StCtrl, {1'b0, r_pctl}, {1'b0, r_ped[6:0]}};
            end
            4'd6: begin
                w_hemit = w_pdmp;
                w_hmsg  = '{krme_pkg::StCtrl, krme_pkg::CcDamper,
                            r_ped[7] ? 8'h7F : 8'h00};
            end
            default: begin
                w_hemit = 1'b0;
                w_hmsg  = '0;
            end
        endcase
        w_hlast = r_hstep == 4'd6;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            krme_pkg::S_IDLE: if (w_acc) n_state = krme_pkg::S_HEAD;
            krme_pkg::S_HEAD: if (w_hlast) n_state = krme_pkg::S_KEYS;
            krme_pkg::S_KEYS:
                if (r_k == KW'(krme_pkg::KeyCount - 1)) n_state = krme_pkg::S_OUT;
            krme_pkg::S_OUT: if (r_rptr == r_wcnt) n_state = krme_pkg::S_IDLE;
                else n_state = krme_pkg::S_DONE;
            krme_pkg::S_DONE:
                if (o_valid && !i_stall && o_last_message) n_state = krme_pkg::S_IDLE;
            default: n_state = krme_pkg::S_IDLE;
        endcase
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= krme_pkg::S_IDLE;
            r_pfb <= '0; r_ptb <= '0; r_pbs <= '0; r_pped <= '0; r_pwh <= '0;
            r_ppad <= '0; r_pkeys <= '0;
            r_base <= krme_pkg::BaseReset;
            r_prog <= '0;
            r_drum <= 1'b0;
            r_pctl <= 7'd11;
            r_held <= '0;
            r_qwe  <= 1'b0;
            r_wcnt <= '0;
            r_rptr <= '0;
            r_hstep <= '0;
            r_k <= '0;
            r_below <= '0;
            o_valid <= 1'b0;
            r_out_wait <= 1'b0;
        end else begin
            r_state <= n_state;
            r_qwe   <= 1'b0;
            case (r_state)
                krme_pkg::S_IDLE: begin
                    r_wcnt  <= '0;
                    r_rptr  <= '0;
                    r_hstep <= '0;
                    r_k     <= '0;
                    r_below <= '0;
                end
                krme_pkg::S_HEAD: begin
                    r_hstep <= r_hstep + 4'd1;
                    if (w_hemit && r_wcnt < CW'(krme_pkg::MaxMsgs)) begin
                        r_qwe    <= 1'b1;
                        r_qwaddr <= r_wcnt[QW-1:0];
                        r_qwdata <= w_hmsg;
                        r_wcnt   <= r_wcnt + CW'(1);
                    end
                    // Program, octave and pad updates land before the pedal
                    // slot reads the selected controller.
                    if (r_hstep == 4'd0) begin
                        r_prog <= w_newprog;
                        // Octave buttons.
                        if ((r_fb[2] && !r_pfb[2] || r_fb[0] && !r_pfb[0])
                                && r_fb[2] && r_fb[0]) begin
                            r_base <= krme_pkg::BaseReset;
                        end else if (r_fb[2] && !r_pfb[2] && r_base <= krme_pkg::BaseTop) begin
                            r_base <= r_base + 7'd12;
                        end else if (r_fb[0] && !r_pfb[0] && r_base >= 7'd12) begin
                            r_base <= r_base - 7'd12;
                        end
                        // Direction pad.
                        if (r_pad != krme_pkg::PadCenter && r_pad != r_ppad) begin
                            if (r_pad == krme_pkg::PadUp) r_drum <= !r_drum;
                            else if (r_pad == krme_pkg::PadLeft) r_pctl <= 7'd11;
                            else if (r_pad == krme_pkg::PadDown) r_pctl <= 7'd7;
                            else if (r_pad == krme_pkg::PadRight) r_pctl <= 7'd4;
                        end
                    end
                end
                krme_pkg::S_KEYS: begin
                    r_k <= r_k + KW'(1);
                    if (w_cv) r_below <= r_below + 5'd1;
                    if (w_chg) begin
                        if (r_wcnt < CW'(krme_pkg::MaxMsgs)) begin
                            r_qwe    <= 1'b1;
                            r_qwaddr <= r_wcnt[QW-1:0];
                            r_wcnt   <= r_wcnt + CW'(1);
                        end
                        if (w_cv) begin
                            r_qwdata <= '{krme_pkg::StNoteOn | {4'd0, w_ch},
                                          {1'b0, w_note}, {1'b0, w_v}};
                            if (w_drumk) r_on_drums[r_k[3:0]] <= (w_ch == 4'd9);
                            r_held <= r_held + 5'd1;
                        end else begin
                            r_qwdata <= '{krme_pkg::StNoteOff |
                                          ((w_drumk && r_on_drums[r_k[3:0]]) ?
                                           8'h09 : 8'h00),
                                          {1'b0, w_nrdata}, {1'b0, krme_pkg::VelDefault}};
                            if (r_held != 5'd0) r_held <= r_held - 5'd1;
                        end
                    end
                    if (n_state == krme_pkg::S_OUT) begin
                        r_pfb <= r_fb; r_ptb <= r_tb; r_pbs <= r_bs;
                        r_pped <= r_ped; r_pwh <= r_wh; r_ppad <= r_pad;
                        r_pkeys <= r_keys;
                    end
                end
                krme_pkg::S_OUT: begin
                    // The last queue write lands at this edge; read entry 0 after it.
                    r_out_wait <= 1'b0;
                end
                krme_pkg::S_DONE: begin
                    if (r_out_wait) begin
                        // Read data valid: present it.
                        o_valid        <= 1'b1;
                        o_midi_status  <= w_qrdata.status;
                        o_midi_data1   <= w_qrdata.data1;
                        o_midi_data2   <= w_qrdata.data2;
                        o_last_message <= (r_rptr + CW'(1) == r_wcnt);
                        r_rptr         <= r_rptr + CW'(1);
                        r_out_wait     <= 1'b0;
                    end else if (o_valid && !i_stall) begin
                        o_valid    <= 1'b0;
                        r_out_wait <= !o_last_message;
                    end else if (!o_valid) begin
                        // First cycle of the walk: the read of entry 0 is in flight.
                        r_out_wait <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Report capture.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_fb <= i_front_buttons; r_tb <= i_transport_buttons;
            r_pad <= i_pad_direction; r_keys <= i_key_bits;
            r_vel[0] <= i_velocity_0; r_vel[1] <= i_velocity_1;
            r_vel[2] <= i_velocity_2; r_vel[3] <= i_velocity_3;
            r_vel[4] <= i_velocity_4;
            r_bs <= i_bend_select; r_ped <= i_pedal_byte; r_wh <= i_wheel_value;
        end
    end
endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Keyboard report to MIDI event testbench
// Sends keyboard reports through the block and compares every MIDI message it
// emits against a behavioral prediction of the report-difference logic.
// ----------------------------------------------------------------------------

// Tracks the keyboard state and holds the MIDI messages still due.
class midi_scoreboard;
    logic [7:0]  prev_front, prev_transport, prev_bend, prev_pedal, prev_wheel;
    logic [3:0]  prev_pad;
    logic [24:0] prev_keys;
    logic [6:0]  base_note, program_num, pedal_cc;
    logic        drums_on;
    int          held_keys;
    logic [6:0]  key_note [krme_pkg::KeyCount];
    logic        key_on_drums [krme_pkg::DrumKeys];
    logic [24:0] due_msgs [$];
    int          errors;
    int          seen;
    int          reports;

    function new();
        prev_front = 0; prev_transport = 0; prev_bend = 0; prev_pedal = 0;
        prev_wheel = 0; prev_pad = 0; prev_keys = 0;
        base_note = krme_pkg::BaseReset; program_num = 0; pedal_cc = 7'd11;
        drums_on = 0; held_keys = 0; errors = 0; seen = 0; reports = 0;
        foreach (key_note[i]) key_note[i] = 0;
        foreach (key_on_drums[i]) key_on_drums[i] = 0;
    endfunction

    function bit rose(logic [7:0] cur, logic [7:0] old, logic [7:0] m);
        return ((cur & m) == m) && ((old & m) == 0);
    endfunction

    function void add(ref logic [23:0] buf_q[$], input logic [7:0] st, d1, d2);
        if (buf_q.size() < krme_pkg::MaxMsgs) buf_q.push_back({st, d1, d2});
    endfunction

    // Notes one accepted report and queues the messages it should cause.
    function void note_report(logic [7:0] fb, tbt, logic [3:0] pad, logic [24:0] keys,
                              logic [6:0] vel [5], logic [7:0] bs, ped, wh);
        logic [23:0] msgs [$];
        bit up, dn, st, co, sp, cv, lv;
        int below;
        logic [3:0] ch;
        logic [6:0] note, v;
        below = 0;
        reports++;
        // Octave buttons.
        up = rose(fb, prev_front, 8'h04); dn = rose(fb, prev_front, 8'h01);
        if ((up || dn) && fb[0] && fb[2]) base_note = krme_pkg::BaseReset;
        else if (up && base_note <= krme_pkg::BaseTop) base_note = base_note + 7'd12;
        else if (dn && base_note >= 7'd12) base_note = base_note - 7'd12;
        // Patch buttons.
        up = rose(fb, prev_front, 8'h08); dn = rose(fb, prev_front, 8'h02);
        if ((up || dn) && fb[1] && fb[3]) program_num = 0;
        else if (up) program_num = program_num + 7'd1;
        else if (dn) program_num = program_num - 7'd1;
        if (up || dn) add(msgs, krme_pkg::StProgram, {1'b0, program_num}, 8'd0);
        // Transport.
        st = rose(tbt, prev_transport, 8'h02);
        co = rose(tbt, prev_transport, 8'h10);
        sp = rose(tbt, prev_transport, 8'h01);
        if ((st || co || sp) && ((tbt & 8'h13) == 8'h13)) begin
            add(msgs, krme_pkg::StStop, 8'd0, 8'd0);
            add(msgs, krme_pkg::StCtrl, krme_pkg::CcAllOff, 8'd0);
            add(msgs, krme_pkg::StCtrlDrum, krme_pkg::CcAllOff, 8'd0);
        end else if (st) add(msgs, krme_pkg::StStart, 8'd0, 8'd0);
        else if (co) add(msgs, krme_pkg::StContinue, 8'd0, 8'd0);
        else if (sp) add(msgs, krme_pkg::StStop, 8'd0, 8'd0);
        // Touch strip.
        if (wh != prev_wheel && bs == prev_bend && wh != 0) begin
            if (bs[7]) add(msgs, krme_pkg::StBend, 8'd0, wh - 8'd1);
            else add(msgs, krme_pkg::StCtrl, krme_pkg::CcMod, wh - 8'd1);
        end
        // Direction pad.
        if (pad != krme_pkg::PadCenter && pad != prev_pad) begin
            if (pad == krme_pkg::PadUp) drums_on = !drums_on;
            else if (pad == krme_pkg::PadLeft) pedal_cc = 7'd11;
            else if (pad == krme_pkg::PadDown) pedal_cc = 7'd7;
            else if (pad == krme_pkg::PadRight) pedal_cc = 7'd4;
        end
        // Pedal and damper.
        if (ped[6:0] != prev_pedal[6:0])
            add(msgs, krme_pkg::StCtrl, {1'b0, pedal_cc}, {1'b0, ped[6:0]});
        if (ped[7] != prev_pedal[7])
            add(msgs, krme_pkg::StCtrl, krme_pkg::CcDamper, ped[7] ? 8'h7F : 8'h00);
        // Keys, lowest first.
        for (int k = 0; k < krme_pkg::KeyCount; k++) begin
            cv = keys[krme_pkg::KeyCount-1-k]; lv = prev_keys[krme_pkg::KeyCount-1-k];
            if (cv && !lv) begin
                ch = 0; note = base_note + k[6:0]; v = krme_pkg::VelDefault;
                if (k < krme_pkg::DrumKeys) begin
                    if (drums_on) begin
                        ch = 9;
                        note = krme_pkg::drum_note(k[krme_pkg::KeyIdxW-1:0]);
                    end
                    key_on_drums[k] = drums_on;
                end
                if (held_keys < krme_pkg::VelocitySlots && below < krme_pkg::VelocitySlots)
                    v = vel[below];
                add(msgs, krme_pkg::StNoteOn | {4'd0, ch}, {1'b0, note}, {1'b0, v});
                key_note[k] = note;
                held_keys++;
            end else if (!cv && lv) begin
                ch = (k < krme_pkg::DrumKeys && key_on_drums[k]) ? 4'd9 : 4'd0;
                add(msgs, krme_pkg::StNoteOff | {4'd0, ch}, {1'b0, key_note[k]},
                    {1'b0, krme_pkg::VelDefault});
                if (held_keys > 0) held_keys--;
            end
            if (cv) below++;
        end
        prev_front = fb; prev_transport = tbt; prev_pad = pad; prev_keys = keys;
        prev_bend = bs; prev_pedal = ped; prev_wheel = wh;
        foreach (msgs[i]) due_msgs.push_back({msgs[i], i == msgs.size() - 1});
    endfunction

    // Compares one emitted message with the oldest one due.
    function void check_msg(logic [7:0] st, d1, d2, logic last);
        logic [24:0] e;
        seen++;
        if (due_msgs.size() == 0) begin
            $error("unexpected message %h %h %h last=%b", st, d1, d2, last);
            errors++;
            return;
        end
        e = due_msgs.pop_front();
        if (st !== e[24:17]) begin
            $error("midi_status expected %h got %h", e[24:17], st); errors++;
        end
        if (d1 !== e[16:9]) begin
            $error("midi_data1 expected %h got %h", e[16:9], d1); errors++;
        end
        if (d2 !== e[8:1]) begin
            $error("midi_data2 expected %h got %h", e[8:1], d2); errors++;
        end
        if (last !== e[0]) begin
            $error("last_message expected %b got %b", e[0], last); errors++;
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    logic [7:0]  i_front_buttons, i_transport_buttons, i_bend_select, i_pedal_byte;
    logic [7:0]  i_wheel_value;
    logic [3:0]  i_pad_direction;
    logic [24:0] i_key_bits;
    logic [6:0]  i_velocity_0, i_velocity_1, i_velocity_2, i_velocity_3, i_velocity_4;
    logic [7:0]  o_midi_status, o_midi_data1, o_midi_data2;
    logic        o_last_message;

    midi_scoreboard board;
    int send_idle_pct, stall_pct;

    keyboard_report_to_midi_events_top DUT (.*);

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: random stall, sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_msg(o_midi_status, o_midi_data1, o_midi_data2, o_last_message);
    end
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Drives one report and waits until it is accepted. Valid drops only
    // while the sender idles, so the next item follows without a gap.
    task automatic send_report(logic [7:0] fb, tbt, logic [3:0] pad, logic [24:0] keys,
                               logic [7:0] bs, ped, wh);
        logic [6:0] vel [5];
        foreach (vel[i]) vel[i] = 7'($urandom_range(127));
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_front_buttons <= fb; i_transport_buttons <= tbt; i_pad_direction <= pad;
        i_key_bits <= keys; i_bend_select <= bs; i_pedal_byte <= ped; i_wheel_value <= wh;
        i_velocity_0 <= vel[0]; i_velocity_1 <= vel[1]; i_velocity_2 <= vel[2];
        i_velocity_3 <= vel[3]; i_velocity_4 <= vel[4];
        do @(posedge i_clk); while (o_stall);
        board.note_report(fb, tbt, pad, keys, vel, bs, ped, wh);
        @(negedge i_clk);
    endtask

    // Random report: mostly small edits to the previous one so presses,
    // releases and held chords all occur.
    task automatic random_report();
        logic [7:0] fb, tbt, bs, ped, wh;
        logic [3:0] pad;
        logic [24:0] keys;
        fb = board.prev_front; tbt = board.prev_transport; pad = board.prev_pad;
        keys = board.prev_keys; bs = board.prev_bend; ped = board.prev_pedal;
        wh = board.prev_wheel;
        if ($urandom_range(9) == 0) begin
            fb = 8'($urandom); tbt = 8'($urandom); pad = 4'($urandom);
            keys = 25'($urandom); bs = 8'($urandom); ped = 8'($urandom);
            wh = 8'($urandom);
        end else begin
            if ($urandom_range(3) == 0) fb[$urandom_range(7)] ^= 1'b1;
            if ($urandom_range(3) == 0) tbt[$urandom_range(7)] ^= 1'b1;
            if ($urandom_range(3) == 0)
                pad = ($urandom_range(3) == 0) ? 4'($urandom) : krme_pkg::PadCenter;
            if ($urandom_range(3) == 0) pad = 4'($urandom_range(4) * 2);
            repeat ($urandom_range(3)) keys[$urandom_range(24)] ^= 1'b1;
            if ($urandom_range(2) == 0) wh = 8'($urandom);
            if ($urandom_range(7) == 0) bs = 8'($urandom);
            if ($urandom_range(3) == 0) ped = 8'($urandom);
        end
        send_report(fb, tbt, pad, keys, bs, ped, wh);
    endtask

    initial begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        int guard;
        board = new();
        send_idle_pct = 0; stall_pct = 0;
        i_rst_n = 0; i_valid = 0; i_stall = 0;
        i_front_buttons = 0; i_transport_buttons = 0; i_pad_direction = 0;
        i_key_bits = 0; i_bend_select = 0; i_pedal_byte = 0; i_wheel_value = 0;
        i_velocity_0 = 0; i_velocity_1 = 0; i_velocity_2 = 0; i_velocity_3 = 0;
        i_velocity_4 = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: patch wrap and reset, octave limits, transport, wheel, pad, keys.
        send_report(8'h02, 8'h00, krme_pkg::PadCenter, 25'd0, 8'h00, 8'h00, 8'd0);
        send_report(8'h00, 8'h00, krme_pkg::PadCenter, 25'd0, 8'h00, 8'h00, 8'd0);
        send_report(8'h08, 8'h00, krme_pkg::PadCenter, 25'd0, 8'h00, 8'h00, 8'd0);
        send_report(8'h0A, 8'h00, krme_pkg::PadCenter, 25'd0, 8'h00, 8'h00, 8'd0);
        for (int i = 0; i < 5; i++) begin
            send_report(8'h00, 8'h00, krme_pkg::PadCenter, 25'd0, 8'h00, 8'h00, 8'd0);
            send_report(8'h04, 8'h00, krme_pkg::PadCenter, 25'd0, 8'h00, 8'h00, 8'd0);
        end
        send_report(8'h05, 8'h13, krme_pkg::PadCenter, 25'h1FFFFFF, 8'h00, 8'hFF, 8'd255);
        send_report(8'h00, 8'h02, krme_pkg::PadUp, 25'h1FFFFFF, 8'h00, 8'h7F, 8'd1);
        send_report(8'h01, 8'h12, krme_pkg::PadLeft, 25'd0, 8'h80, 8'h80, 8'd1);
        send_report(8'h00, 8'h00, krme_pkg::PadDown, 25'h1555555, 8'h80, 8'h00, 8'd200);
        send_report(8'h00, 8'h01, krme_pkg::PadRight, 25'd0, 8'h80, 8'h00, 8'd0);
        send_report(8'h00, 8'h10, krme_pkg::PadUp, 25'h1FF0000, 8'h80, 8'h33, 8'd7);
        send_report(8'hFF, 8'hFF, 4'hF, 25'h0000001, 8'h00, 8'h80, 8'd9);

        // Random phases with different sender-idle and receiver-stall mixes.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 53 : 28) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 53 : 28) : 0;
            repeat (90) random_report();
        end
        i_valid <= 0;

        guard = 0;
        while (board.due_msgs.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
        if (board.due_msgs.size() != 0) begin
            $error("%0d messages never arrived", board.due_msgs.size());
            board.errors++;
        end
        $display("Sent %0d reports and checked %0d MIDI messages under four idle mixes.",
                 board.reports, board.seen);
        if (board.errors == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
design/krme_pkg.sv
design/krme_ram.sv
design/keyboard_report_to_midi_events_top.sv
verif/tb.sv
